FILE: sv/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended byte queue core.
// ----------------------------------------------------------------------------
package deq_pkg;

	localparam int DEPTH  = 128;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int BYTE_W = 8;
	localparam int QCNT_W = 8;

	localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
	localparam logic [1:0] OP_PUSH_REAR  = 2'd1;
	localparam logic [1:0] OP_POP_FRONT  = 2'd2;
	localparam logic [1:0] OP_POP_REAR   = 2'd3;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_UNDERFLOW = 2'd1;
	localparam logic [1:0] STAT_OVERFLOW  = 2'd2;

	typedef struct packed {
		logic [1:0]        op;
		logic [BYTE_W-1:0] data_in;
	} cmd_t;

	typedef struct packed {
		logic [BYTE_W-1:0] popped_value;
		logic [BYTE_W-1:0] front_value;
		logic [BYTE_W-1:0] rear_value;
		logic [QCNT_W-1:0] entry_count;
		logic [1:0]        status;
	} result_t;

	typedef struct packed {
		logic              push;
		logic              rear;
		logic [BYTE_W-1:0] data;
	} job_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} job_req_t;

endpackage

FILE: sv/deq_front.sv
// ----------------------------------------------------------------------------
// deq_front
// Accepts commands, decodes them into jobs and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module deq_front import deq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  cmd_t     cmd,
	output logic     busy,
	output job_req_t req,
	input  logic     take
);

	job_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] used_q;
	logic       push_en;
	logic       pop_en;
	job_t       job_new;

	always_comb begin
		job_new.data = cmd.data_in;
		job_new.push = 1'b0;
		job_new.rear = 1'b0;
		unique case (cmd.op)
			OP_PUSH_FRONT: begin
				job_new.push = 1'b1;
				job_new.rear = 1'b0;
			end
			OP_PUSH_REAR: begin
				job_new.push = 1'b1;
				job_new.rear = 1'b1;
			end
			OP_POP_FRONT: begin
				job_new.push = 1'b0;
				job_new.rear = 1'b0;
			end
			OP_POP_REAR: begin
				job_new.push = 1'b0;
				job_new.rear = 1'b1;
			end
			default: begin
				job_new.push = 1'b0;
				job_new.rear = 1'b0;
			end
		endcase
	end

	assign busy      = (used_q == 2'd2);
	assign push_en   = start && !busy;
	assign req.valid = (used_q != 2'd0);
	assign req.job   = slot_q[rd_ptr_q];
	assign pop_en    = take && req.valid;

	always_ff @(posedge clk) begin
		if (push_en) begin
			slot_q[wr_ptr_q] <= job_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			used_q   <= 2'd0;
		end else begin
			if (push_en) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop_en) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push_en && !pop_en) begin
				used_q <= used_q + 2'd1;
			end else if (pop_en && !push_en) begin
				used_q <= used_q - 2'd1;
			end
		end
	end

endmodule

FILE: sv/deq_back.sv
// ----------------------------------------------------------------------------
// deq_back
// Executes queued jobs on the ring buffer and registers one result per job.
// ----------------------------------------------------------------------------
module deq_back import deq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  job_req_t req,
	output logic     take,
	output logic     done,
	output result_t  result
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_READ = 1'b1;

	logic [BYTE_W-1:0] mem [DEPTH];
	logic [BYTE_W-1:0] rdata_q;

	logic              state_q, state_d;
	logic [ADDR_W-1:0] head_q, head_d;
	logic [ADDR_W-1:0] tail_q, tail_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [BYTE_W-1:0] front_q, front_d;
	logic [BYTE_W-1:0] rear_q, rear_d;
	logic [BYTE_W-1:0] popped_q, popped_d;
	logic              side_q, side_d;
	logic              done_q, done_d;
	result_t           res_q, res_d;

	logic [ADDR_W-1:0] head_inc, head_dec, tail_inc, tail_dec;
	logic [ADDR_W-1:0] waddr, raddr;
	logic              we;

	assign head_inc = (head_q == ADDR_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign head_dec = (head_q == '0) ? ADDR_W'(DEPTH - 1) : head_q - 1'b1;
	assign tail_inc = (tail_q == ADDR_W'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
	assign tail_dec = (tail_q == '0) ? ADDR_W'(DEPTH - 1) : tail_q - 1'b1;

	always_comb begin
		state_d  = state_q;
		head_d   = head_q;
		tail_d   = tail_q;
		cnt_d    = cnt_q;
		front_d  = front_q;
		rear_d   = rear_q;
		popped_d = popped_q;
		side_d   = side_q;
		done_d   = 1'b0;
		take     = 1'b0;
		we       = 1'b0;
		waddr    = head_dec;
		raddr    = head_inc;
		res_d    = res_q;
		res_d.popped_value = '0;
		res_d.status       = STAT_OK;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					take = 1'b1;
					if (req.job.push) begin
						done_d = 1'b1;
						if (cnt_q == CNT_W'(DEPTH)) begin
							res_d.status = STAT_OVERFLOW;
						end else begin
							we    = 1'b1;
							cnt_d = cnt_q + 1'b1;
							if (req.job.rear) begin
								waddr  = tail_inc;
								tail_d = tail_inc;
								rear_d = req.job.data;
								if (cnt_q == '0) begin
									front_d = req.job.data;
								end
							end else begin
								waddr   = head_dec;
								head_d  = head_dec;
								front_d = req.job.data;
								if (cnt_q == '0) begin
									rear_d = req.job.data;
								end
							end
						end
					end else if (cnt_q == '0) begin
						done_d       = 1'b1;
						res_d.status = STAT_UNDERFLOW;
					end else begin
						cnt_d    = cnt_q - 1'b1;
						popped_d = req.job.rear ? rear_q : front_q;
						side_d   = req.job.rear;
						if (req.job.rear) begin
							tail_d = tail_dec;
							raddr  = tail_dec;
						end else begin
							head_d = head_inc;
							raddr  = head_inc;
						end
						if (cnt_q == CNT_W'(1)) begin
							done_d             = 1'b1;
							res_d.popped_value = popped_d;
						end else begin
							state_d = ST_READ;
						end
					end
				end
			end
			ST_READ: begin
				if (side_q) begin
					rear_d = rdata_q;
				end else begin
					front_d = rdata_q;
				end
				done_d             = 1'b1;
				res_d.popped_value = popped_q;
				state_d            = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		res_d.entry_count = QCNT_W'(cnt_d);
		res_d.front_value = (cnt_d == '0) ? '0 : front_d;
		res_d.rear_value  = (cnt_d == '0) ? '0 : rear_d;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= req.job.data;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		front_q  <= front_d;
		rear_q   <= rear_d;
		popped_q <= popped_d;
		side_q   <= side_d;
		res_q    <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= ADDR_W'(DEPTH - 1);
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			cnt_q   <= cnt_d;
			done_q  <= done_d;
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

FILE: sv/double_ended_queue_core.sv
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Bounded double-ended byte queue on a ring buffer with one result per item.
//
//   channel   handshake        payload
//   command   start / busy     cmd    (op, data_in)
//   result    done (strobe)    result (popped, front, rear, count, status)
//
// A push, an overflow, an underflow or a pop that empties the queue ends in the
// execution unit's idle state; a pop that leaves bytes also passes its read
// state, bound by the registered read of the slot memory, and blocks the next
// job until it is through. Pushes sustain one item per cycle while no such pop
// holds the unit. done is registered behind the job queue slot, the execution
// unit and, for such pops, the read state. busy rises when the two-entry job
// queue is full. Reset leaves the queue empty; no clearing pass is needed.
// ----------------------------------------------------------------------------
module double_ended_queue_core import deq_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  cmd_t    cmd,
	output logic    busy,
	output logic    done,
	output result_t result
);

	job_req_t req;
	logic     take;

	deq_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.req    (req),
		.take   (take)
	);

	deq_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.take   (take),
		.done   (done),
		.result (result)
	);

`ifndef SYNTHESIS
	a_underflow_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == STAT_UNDERFLOW |->
			result.popped_value == '0 && result.entry_count == '0)
		else $error("underflow result carries data");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.entry_count == '0 |->
			result.front_value == '0 && result.rear_value == '0)
		else $error("empty queue reports front or rear byte");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> 32'(result.entry_count) <= DEPTH)
		else $error("entry count exceeds depth");

	a_no_done_unless_job: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(take) || $past(u_back.state_q == 1'b1))
		else $error("result without a job");
`endif

endmodule
